[design/pid_steer_limiter_defines.svh]
// ----------------------------------------------------------------------------
// pid_steer_limiter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_STEER_LIMITER_DEFINES_SVH
`define PID_STEER_LIMITER_DEFINES_SVH

// same-cycle implication
`define PSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_steer_limiter: same-cycle check failed");

// next-cycle implication
`define PSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_steer_limiter: next-cycle check failed");

`endif

[design/psl_pkg.sv]
// ----------------------------------------------------------------------------
// psl_pkg
// Widths, register indexes, reset values and limit codes of the steering
// controller.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 15;
  localparam int CSUM_W     = 22;
  localparam int DRV_W      = 14;
  localparam int HIT_W      = 2;
  localparam int SPEED_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_TOTAL_WIDTH = 48;
  localparam int DEF_COUNT_WIDTH = 32;

  localparam int QCLAMP_LOG2 = 40;
  localparam int MAG_W       = QCLAMP_LOG2 + 1;
  localparam int PROD_W      = MAG_W + GAIN_W;
  localparam int SUM_W       = 47;

  localparam int P_SHIFT    = 13;
  localparam int GAIN_FRAC  = 12;
  localparam int SCALE_FRAC = 16;
  localparam int DRV_SHIFT  = GAIN_FRAC + SCALE_FRAC;
  localparam int SPEED_MAX  = 250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_OUTPUT_SCALE = 3'd3,
    REG_BASE_SPEED   = 3'd4,
    REG_MOTOR_GAIN   = 3'd5
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 16'd2048;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 16'd205;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 16'd3482;
  localparam logic [GAIN_W-1:0]  RST_OUTPUT_SCALE = 16'd328;
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED   = 8'd50;
  localparam logic [GAIN_W-1:0]  RST_MOTOR_GAIN   = 16'd4096;

  localparam logic [HIT_W-1:0] LIM_NONE  = 2'd0;
  localparam logic [HIT_W-1:0] LIM_UPPER = 2'd1;
  localparam logic [HIT_W-1:0] LIM_LOWER = 2'd2;

endpackage

[design/psl_serdiv.sv]
// ----------------------------------------------------------------------------
// psl_serdiv
// Restoring divider, one quotient bit per cycle shifted into the dividend
// register.
// ----------------------------------------------------------------------------
module psl_serdiv #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

[design/psl_sermul.sv]
// ----------------------------------------------------------------------------
// psl_sermul
// Shift-add multiplier, one gain bit per cycle, LSB first; the gain shifts
// out of the low end of the product register.
// ----------------------------------------------------------------------------
module psl_sermul #(
  parameter int A_W = 41
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [A_W-1:0]                  a,
  input  logic [psl_pkg::GAIN_W-1:0]      b,
  output logic                            busy,
  output logic [A_W+psl_pkg::GAIN_W-1:0]  product
);

  localparam int B_W   = psl_pkg::GAIN_W;
  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] acc_r;
  logic [A_W:0]       psum;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;

  assign psum = {1'b0, acc_r[A_W+B_W-1:B_W]} + (acc_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(B_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= {{A_W{1'b0}}, b};
    end else if (busy_r) begin
      acc_r <= {psum, acc_r[B_W-1:1]};
    end
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

[design/pid_steer_limiter.sv]
// ----------------------------------------------------------------------------
// pid_steer_limiter
// Fixed-point PID steering controller with speed limiting and motor gain.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only once the sequencer is back
// in idle. The mean error comes from a serial divider giving one quotient bit
// per cycle, and all products come from one bit-serial multiplier, one after
// another; the P and D products run while the divider works, then the I,
// scale and motor products follow in turn. The result sits in an output
// register, so the next item is taken while it waits. Configuration writes
// are taken at any time and must only be made while the block is idle.
`include "pid_steer_limiter_defines.svh"

module pid_steer_limiter #(
  parameter int TOTAL_WIDTH = psl_pkg::DEF_TOTAL_WIDTH,
  parameter int COUNT_WIDTH = psl_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [psl_pkg::ERR_W-1:0]    in_near_error,
  input  logic signed [psl_pkg::ERR_W-1:0]    in_far_error,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psl_pkg::CSUM_W-1:0]   out_control_sum,
  output logic signed [psl_pkg::DRV_W-1:0]    out_drive,
  output logic [psl_pkg::HIT_W-1:0]           out_limit_hit
);

  localparam int GAIN_W  = psl_pkg::GAIN_W;
  localparam int ERR_W   = psl_pkg::ERR_W;
  localparam int CSUM_W  = psl_pkg::CSUM_W;
  localparam int DRV_W   = psl_pkg::DRV_W;
  localparam int HIT_W   = psl_pkg::HIT_W;
  localparam int SPEED_W = psl_pkg::SPEED_W;
  localparam int MAG_W   = psl_pkg::MAG_W;
  localparam int PROD_W  = psl_pkg::PROD_W;
  localparam int SUM_W   = psl_pkg::SUM_W;
  localparam int PD_W    = ERR_W + 1;
  localparam int SCM_W   = CSUM_W + GAIN_W;
  localparam int SC_W    = SCM_W + 1;
  localparam int LIM_W   = SPEED_W + 2;
  localparam int QX_W    = 65;
  localparam int DM_W    = PROD_W - psl_pkg::DRV_SHIFT;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PMUL  = 10'b0000000010,
    S_DMUL  = 10'b0000000100,
    S_DIVW  = 10'b0000001000,
    S_IMUL  = 10'b0000010000,
    S_SUM   = 10'b0000100000,
    S_SMUL  = 10'b0001000000,
    S_LIMIT = 10'b0010000000,
    S_MMUL  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]  prop_r, integ_r, deriv_r, scale_r, motor_r;
  logic [SPEED_W-1:0] base_r;

  logic signed [TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic [COUNT_WIDTH-1:0]        count_r, count_nxt;
  logic signed [TOTAL_WIDTH:0]   tsum;
  logic [TOTAL_WIDTH-1:0]        total_mag;
  logic                          tneg_r;

  logic              in_accept;
  logic signed [PD_W-1:0] pd_s, dd_s;
  logic [PD_W-1:0]   pd_mag, dd_mag;
  logic [PD_W-1:0]   dmag_r;
  logic              dneg_r;

  logic              mul_start, mul_busy;
  logic [MAG_W-1:0]  mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              opneg_r, opneg_nxt;

  logic                   div_busy;
  logic [TOTAL_WIDTH-1:0] div_quot;
  logic [QX_W-1:0]        qx;
  logic [MAG_W-1:0]       q_mag;

  logic signed [SUM_W-1:0] t13, t12, term_p, term_i;
  logic signed [SUM_W-1:0] p_r, d_r, i_r, sum_w;
  logic signed [CSUM_W-1:0] sum_sat, sum_r;
  logic [CSUM_W-1:0]       sum_mag;

  logic [SCM_W-1:0]        scmag_r;
  logic signed [SC_W-1:0]  sc_s, up_th, lo_th;
  logic signed [LIM_W-1:0] up_s, lo_s;
  logic [LIM_W-1:0]        up_abs;
  logic [HIT_W-1:0]        hit_sel, hit_r;
  logic [MAG_W-1:0]        x_mag;
  logic                    x_neg;

  logic [DM_W-1:0]          dm, dm_neg;
  logic signed [DRV_W-1:0]  drive_val;

  logic                     out_valid_r;
  logic signed [CSUM_W-1:0] out_csum_r;
  logic signed [DRV_W-1:0]  out_drive_r;
  logic [HIT_W-1:0]         out_hit_r;
  logic                     out_load;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= psl_pkg::RST_PROP_GAIN;
      integ_r <= psl_pkg::RST_INTEG_GAIN;
      deriv_r <= psl_pkg::RST_DERIV_GAIN;
      scale_r <= psl_pkg::RST_OUTPUT_SCALE;
      base_r  <= psl_pkg::RST_BASE_SPEED;
      motor_r <= psl_pkg::RST_MOTOR_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psl_pkg::REG_PROP_GAIN:    prop_r  <= cfg_data;
        psl_pkg::REG_INTEG_GAIN:   integ_r <= cfg_data;
        psl_pkg::REG_DERIV_GAIN:   deriv_r <= cfg_data;
        psl_pkg::REG_OUTPUT_SCALE: scale_r <= cfg_data;
        psl_pkg::REG_BASE_SPEED:   base_r  <= cfg_data[SPEED_W-1:0];
        psl_pkg::REG_MOTOR_GAIN:   motor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulate
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign tsum = (TOTAL_WIDTH+1)'(total_r) + (TOTAL_WIDTH+1)'(in_near_error);

  always_comb begin
    if (tsum[TOTAL_WIDTH] != tsum[TOTAL_WIDTH-1]) begin
      total_nxt = tsum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}}
                                    : {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    end else begin
      total_nxt = tsum[TOTAL_WIDTH-1:0];
    end
    count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
  end

  assign total_mag = total_nxt[TOTAL_WIDTH-1] ? -total_nxt : total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
    end else if (in_accept) begin
      total_r <= total_nxt;
      count_r <= count_nxt;
    end
  end

  assign pd_s   = PD_W'(in_near_error) + PD_W'(in_far_error);
  assign dd_s   = PD_W'(in_far_error) - PD_W'(in_near_error);
  assign pd_mag = pd_s[PD_W-1] ? -pd_s : pd_s;
  assign dd_mag = dd_s[PD_W-1] ? -dd_s : dd_s;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dmag_r <= dd_mag;
      dneg_r <= dd_s[PD_W-1];
      tneg_r <= total_nxt[TOTAL_WIDTH-1];
    end
  end

  // mean error, clamped
  assign qx    = QX_W'(div_quot);
  assign q_mag = (qx > (QX_W'(1) << psl_pkg::QCLAMP_LOG2))
                 ? (MAG_W'(1) << psl_pkg::QCLAMP_LOG2) : qx[MAG_W-1:0];

  // signed terms from the product
  assign t13    = SUM_W'(mul_prod >> psl_pkg::P_SHIFT);
  assign t12    = SUM_W'(mul_prod >> psl_pkg::GAIN_FRAC);
  assign term_p = opneg_r ? -t13 : t13;
  assign term_i = opneg_r ? -t12 : t12;

  assign sum_w   = p_r + d_r + i_r;
  assign sum_sat = ((&sum_w[SUM_W-1:CSUM_W-1]) || !(|sum_w[SUM_W-1:CSUM_W-1]))
                   ? sum_w[CSUM_W-1:0]
                   : (sum_w[SUM_W-1] ? {1'b1, {(CSUM_W-1){1'b0}}}
                                     : {1'b0, {(CSUM_W-1){1'b1}}});
  assign sum_mag = sum_sat[CSUM_W-1] ? -sum_sat : sum_sat;

  // limit tests
  assign sc_s   = sum_r[CSUM_W-1] ? -SC_W'(scmag_r) : SC_W'(scmag_r);
  assign up_s   = LIM_W'(psl_pkg::SPEED_MAX) - LIM_W'(base_r);
  assign lo_s   = -(LIM_W'(psl_pkg::SPEED_MAX) + LIM_W'(base_r));
  assign up_th  = SC_W'(up_s) <<< psl_pkg::SCALE_FRAC;
  assign lo_th  = SC_W'(lo_s) <<< psl_pkg::SCALE_FRAC;
  assign up_abs = up_s[LIM_W-1] ? -up_s : up_s;

  always_comb begin
    if (sc_s > up_th) begin
      hit_sel = psl_pkg::LIM_UPPER;
      x_neg   = up_s[LIM_W-1];
      x_mag   = MAG_W'(up_abs) << psl_pkg::SCALE_FRAC;
    end else if (sc_s < lo_th) begin
      hit_sel = psl_pkg::LIM_LOWER;
      x_neg   = 1'b1;
      x_mag   = MAG_W'(psl_pkg::SPEED_MAX) << psl_pkg::SCALE_FRAC;
    end else begin
      hit_sel = psl_pkg::LIM_NONE;
      x_neg   = sum_r[CSUM_W-1];
      x_mag   = MAG_W'(scmag_r);
    end
  end

  // drive, truncated and saturated
  assign dm     = mul_prod[PROD_W-1:psl_pkg::DRV_SHIFT];
  assign dm_neg = -dm;

  always_comb begin
    if (opneg_r) begin
      drive_val = (dm > DM_W'(2 ** (DRV_W - 1))) ? {1'b1, {(DRV_W-1){1'b0}}}
                                                 : dm_neg[DRV_W-1:0];
    end else begin
      drive_val = (dm > DM_W'(2 ** (DRV_W - 1) - 1)) ? {1'b0, {(DRV_W-1){1'b1}}}
                                                     : dm[DRV_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    opneg_nxt = opneg_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          mul_start = 1'b1;
          mul_a     = MAG_W'(pd_mag);
          mul_b     = prop_r;
          opneg_nxt = pd_s[PD_W-1];
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_a     = MAG_W'(dmag_r);
          mul_b     = deriv_r;
          opneg_nxt = dneg_r;
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: begin
        if (!mul_busy) begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (!div_busy) begin
          mul_start = 1'b1;
          mul_a     = q_mag;
          mul_b     = integ_r;
          opneg_nxt = tneg_r;
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: begin
        if (!mul_busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        mul_start = 1'b1;
        mul_a     = MAG_W'(sum_mag);
        mul_b     = scale_r;
        opneg_nxt = sum_sat[CSUM_W-1];
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        if (!mul_busy) begin
          state_nxt = S_LIMIT;
        end
      end
      S_LIMIT: begin
        mul_start = 1'b1;
        mul_a     = x_mag;
        mul_b     = motor_r;
        opneg_nxt = x_neg;
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        if (!mul_busy && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      opneg_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      opneg_r <= opneg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PMUL && !mul_busy) begin
      p_r <= term_p;
    end
    if (state_r == S_DMUL && !mul_busy) begin
      d_r <= term_i;
    end
    if (state_r == S_IMUL && !mul_busy) begin
      i_r <= term_i;
    end
    if (state_r == S_SUM) begin
      sum_r <= sum_sat;
    end
    if (state_r == S_SMUL && !mul_busy) begin
      scmag_r <= mul_prod[SCM_W-1:0];
    end
    if (state_r == S_LIMIT) begin
      hit_r <= hit_sel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_csum_r  <= sum_r;
      out_drive_r <= drive_val;
      out_hit_r   <= hit_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_control_sum = out_csum_r;
  assign out_drive       = out_drive_r;
  assign out_limit_hit   = out_hit_r;

  psl_sermul #(
    .A_W (MAG_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  psl_serdiv #(
    .DVD_W (TOTAL_WIDTH),
    .DVS_W (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .dividend (total_mag),
    .divisor  (count_nxt),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  `PSL_ASSERT_IMP(a_mul_start_idle, mul_start, !mul_busy)
  `PSL_ASSERT_IMP(a_div_done_before_i, state_r == S_IMUL, !div_busy)
  `PSL_ASSERT_NXT(a_count_nonzero, in_accept, count_r != '0)
  `PSL_ASSERT_IMP(a_hit_code, out_valid_r,
                  out_hit_r != (psl_pkg::LIM_UPPER | psl_pkg::LIM_LOWER))

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the steering controller. A directed table of items
// and register writes is walked first, then blocks of random items under
// changing register settings and sender/receiver gaps. Each result is compared
// field by field with a table value or a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import psl_pkg::*;

  localparam int     TOTAL_W        = DEF_TOTAL_WIDTH;
  localparam int     COUNT_W        = DEF_COUNT_WIDTH;
  localparam int     RESET_CYCLES   = 5;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     TAIL_CYCLES    = 150;
  localparam int     BLOCKS         = 15;
  localparam int     BLOCK_ITEMS    = 50;
  localparam int     ERR_MAX        = 12720;
  localparam int     ERR_MIN        = -12880;
  localparam longint SCALE_ONE      = longint'(1) << SCALE_FRAC;
  localparam longint CSUM_MAX       = (longint'(1) << (CSUM_W - 1)) - 1;
  localparam longint DRV_MAX        = (longint'(1) << (DRV_W - 1)) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [CSUM_W-1:0] control_sum;
    logic signed [DRV_W-1:0]  drive;
    logic [HIT_W-1:0]         limit_hit;
  } steer_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    int            a;
    int            b;
    bit            known;
    steer_result_t res;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [ERR_W-1:0]     in_near_error;
  logic signed [ERR_W-1:0]     in_far_error;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [CSUM_W-1:0]    out_control_sum;
  logic signed [DRV_W-1:0]     out_drive;
  logic [HIT_W-1:0]            out_limit_hit;

  logic [GAIN_W-1:0]  prop_g, integ_g, deriv_g, scale_g, motor_g;
  logic [SPEED_W-1:0] speed_base;
  longint             err_total;
  longint             sample_cnt;

  steer_result_t expected_steer_q[$];
  stim_row_t     stim_table[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            in_idle_pct;
  int            out_idle_pct;

  cfg_reg_t all_regs[6] = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN,
                            REG_OUTPUT_SCALE, REG_BASE_SPEED, REG_MOTOR_GAIN};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pid_steer_limiter #(
    .TOTAL_WIDTH (TOTAL_W),
    .COUNT_WIDTH (COUNT_W)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_near_error   (in_near_error),
    .in_far_error    (in_far_error),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_control_sum (out_control_sum),
    .out_drive       (out_drive),
    .out_limit_hit   (out_limit_hit)
  );

  function automatic longint mul_trunc(input longint v, input longint g, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * g) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic steer_result_t predict_steer(input logic signed [ERR_W-1:0] near_e,
                                                  input logic signed [ERR_W-1:0] far_e);
    longint        nv, fv, tmax, tmin, cmax, q, p, d, ip, sum, sc, up, drv;
    steer_result_t r;
    nv   = near_e;
    fv   = far_e;
    tmax = (longint'(1) << (TOTAL_W - 1)) - 1;
    tmin = -tmax - 1;
    cmax = (longint'(1) << COUNT_W) - 1;

    if (nv > 0 && err_total > tmax - nv)
      err_total = tmax;
    else if (nv < 0 && err_total < tmin - nv)
      err_total = tmin;
    else
      err_total = err_total + nv;
    if (sample_cnt < cmax)
      sample_cnt = sample_cnt + 1;

    p = mul_trunc(nv + fv, longint'(prop_g), P_SHIFT);
    d = mul_trunc(fv - nv, longint'(deriv_g), GAIN_FRAC);
    q = ((err_total < 0) ? -err_total : err_total) / sample_cnt;
    if (q > (longint'(1) << QCLAMP_LOG2))
      q = longint'(1) << QCLAMP_LOG2;
    ip = mul_trunc((err_total < 0) ? -q : q, longint'(integ_g), GAIN_FRAC);

    sum = clip(p + d + ip, -CSUM_MAX - 1, CSUM_MAX);
    sc  = sum * longint'(scale_g);
    up  = longint'(SPEED_MAX) - longint'(speed_base);
    if (sc > up * SCALE_ONE) begin
      r.limit_hit = LIM_UPPER;
      drv = mul_trunc(up, longint'(motor_g), GAIN_FRAC);
    end else if (sc + longint'(speed_base) * SCALE_ONE < -longint'(SPEED_MAX) * SCALE_ONE) begin
      r.limit_hit = LIM_LOWER;
      drv = mul_trunc(-longint'(SPEED_MAX), longint'(motor_g), GAIN_FRAC);
    end else begin
      r.limit_hit = LIM_NONE;
      drv = mul_trunc(sc, longint'(motor_g), DRV_SHIFT);
    end
    drv = clip(drv, -DRV_MAX - 1, DRV_MAX);

    r.control_sum = sum[CSUM_W-1:0];
    r.drive       = drv[DRV_W-1:0];
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PROP_GAIN:    prop_g     = data;
      REG_INTEG_GAIN:   integ_g    = data;
      REG_DERIV_GAIN:   deriv_g    = data;
      REG_OUTPUT_SCALE: scale_g    = data;
      REG_BASE_SPEED:   speed_base = data[SPEED_W-1:0];
      REG_MOTOR_GAIN:   motor_g    = data;
      default: ;
    endcase
  endfunction

  function automatic steer_result_t res_of(input int cs, input int dr, input logic [HIT_W-1:0] hit);
    steer_result_t r;
    r.control_sum = cs[CSUM_W-1:0];
    r.drive       = dr[DRV_W-1:0];
    r.limit_hit   = hit;
    return r;
  endfunction

  function automatic void add_item(input int n, input int f, input bit known = 1'b0,
                                   input steer_result_t res = '0);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.a     = n;
    row.b     = f;
    row.known = known;
    row.res   = res;
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.a     = int'(idx);
    row.b     = int'(data);
    row.known = 1'b0;
    row.res   = '0;
    stim_table.push_back(row);
  endfunction

  function automatic int rand_err();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return ERR_MAX;
    if (r == 1) return ERR_MIN;
    if (r < 6) return int'($urandom_range(0, 128)) - 64;
    return int'($urandom_range(0, ERR_MAX - ERR_MIN)) + ERR_MIN;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cfg(input logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 7);
    if (idx == REG_BASE_SPEED) begin
      if (r == 0) return '0;
      if (r == 1) return CFG_DATA_W'(SPEED_MAX);
      if (r == 2) return '1;
      return CFG_DATA_W'($urandom_range(0, 65535));
    end
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (idx == REG_OUTPUT_SCALE && r < 5) return CFG_DATA_W'($urandom_range(0, 2047));
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic signed [ERR_W-1:0] n, input logic signed [ERR_W-1:0] f,
                           input bit known = 1'b0, input steer_result_t want = '0);
    steer_result_t pred;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid      <= 1'b1;
    in_near_error <= n;
    in_far_error  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_steer(n, f);
    expected_steer_q.push_back(known ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_steer_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < out_idle_pct);

  always @(posedge clk) begin
    steer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steer_q.size() == 0) begin
        flag_mismatch("unexpected item, control_sum", out_control_sum, 0);
      end else begin
        want = expected_steer_q.pop_front();
        if (out_control_sum !== want.control_sum)
          flag_mismatch("control_sum", out_control_sum, want.control_sum);
        if (out_drive !== want.drive)
          flag_mismatch("drive", out_drive, want.drive);
        if (out_limit_hit !== want.limit_hit)
          flag_mismatch("limit_hit", out_limit_hit, want.limit_hit);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int f;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_PROP_GAIN;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_near_error = '0;
    in_far_error  = '0;
    in_idle_pct   = 6;
    out_idle_pct  = 61;
    prop_g        = RST_PROP_GAIN;
    integ_g       = RST_INTEG_GAIN;
    deriv_g       = RST_DERIV_GAIN;
    scale_g       = RST_OUTPUT_SCALE;
    speed_base    = RST_BASE_SPEED;
    motor_g       = RST_MOTOR_GAIN;
    err_total     = 0;
    sample_cnt    = 0;

    // reset settings
    add_item(0, 0, 1'b1, res_of(0, 0, LIM_NONE));
    add_item(ERR_MAX, ERR_MAX);
    add_item(ERR_MIN, ERR_MIN);
    add_item(ERR_MAX, ERR_MIN);
    add_item(ERR_MIN, ERR_MAX);
    add_item(-1, 1);
    // difference term alone at unity gain, full scale
    add_cfg(REG_PROP_GAIN, '0);
    add_cfg(REG_INTEG_GAIN, '0);
    add_cfg(REG_DERIV_GAIN, 16'd4096);
    add_cfg(REG_OUTPUT_SCALE, '1);
    add_item(ERR_MIN, ERR_MAX, 1'b1, res_of(25600, 200, LIM_UPPER));
    add_item(ERR_MAX, ERR_MIN, 1'b1, res_of(-25600, -250, LIM_LOWER));
    add_item(5, 5, 1'b1, res_of(0, 0, LIM_NONE));
    // every gain at its top, base speed at SPEED_MAX
    add_cfg(REG_PROP_GAIN, '1);
    add_cfg(REG_INTEG_GAIN, '1);
    add_cfg(REG_DERIV_GAIN, '1);
    add_cfg(REG_MOTOR_GAIN, '1);
    add_cfg(REG_BASE_SPEED, CFG_DATA_W'(SPEED_MAX));
    add_item(ERR_MAX, ERR_MAX);
    add_item(ERR_MIN, ERR_MIN);
    add_item(ERR_MAX, ERR_MIN);
    add_item(ERR_MIN, ERR_MAX);
    add_item(0, 0);
    // base speed above 250: negative upper limit
    add_cfg(REG_PROP_GAIN, '0);
    add_cfg(REG_INTEG_GAIN, '0);
    add_cfg(REG_DERIV_GAIN, 16'd4096);
    add_cfg(REG_BASE_SPEED, '1);
    add_item(0, 0);
    add_item(-100, -101);
    add_item(ERR_MAX, ERR_MIN);
    // all zero; spare indexes must leave every register alone
    add_cfg(REG_DERIV_GAIN, '0);
    add_cfg(REG_OUTPUT_SCALE, '0);
    add_cfg(REG_BASE_SPEED, '0);
    add_cfg(REG_MOTOR_GAIN, '0);
    add_cfg(REG_SPARE_6, '1);
    add_cfg(REG_SPARE_7, '1);
    add_item(ERR_MAX, ERR_MIN, 1'b1, res_of(0, 0, LIM_NONE));
    add_item(ERR_MIN, ERR_MAX, 1'b1, res_of(0, 0, LIM_NONE));
    // reset values again; upper byte of base speed dropped
    add_cfg(REG_PROP_GAIN, RST_PROP_GAIN);
    add_cfg(REG_INTEG_GAIN, RST_INTEG_GAIN);
    add_cfg(REG_DERIV_GAIN, RST_DERIV_GAIN);
    add_cfg(REG_OUTPUT_SCALE, RST_OUTPUT_SCALE);
    add_cfg(REG_BASE_SPEED, {8'hFF, RST_BASE_SPEED});
    add_cfg(REG_MOTOR_GAIN, RST_MOTOR_GAIN);
    add_item(100, -100);
    add_item(ERR_MIN, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        drain();
        write_reg(CFG_IDX_W'(stim_table[i].a), CFG_DATA_W'(stim_table[i].b));
      end else begin
        send_item(ERR_W'(stim_table[i].a), ERR_W'(stim_table[i].b),
                  stim_table[i].known, stim_table[i].res);
      end
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      drain();
      case (blk / 5)
        0: begin
          in_idle_pct  = 6;
          out_idle_pct = 61;
        end
        1: begin
          in_idle_pct  = 61;
          out_idle_pct = 6;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      foreach (all_regs[r])
        write_reg(all_regs[r], pick_cfg(all_regs[r]));
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                  CFG_DATA_W'($urandom_range(0, 65535)));
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        n = rand_err();
        f = ($urandom_range(0, 7) == 0) ? n : rand_err();
        send_item(ERR_W'(n), ERR_W'(f));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_steer_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/psl_pkg.sv
design/psl_serdiv.sv
design/psl_sermul.sv
design/pid_steer_limiter.sv
tb/tb.sv
